// ===== rtl/accel_decay_slew_follower_assert.svh =====
// ----------------------------------------------------------------------------
// accel_decay_slew_follower assertion macros
// shared property forms for the checker of the slew follower
// ----------------------------------------------------------------------------
`ifndef ACCEL_DECAY_SLEW_FOLLOWER_ASSERT_SVH
`define ACCEL_DECAY_SLEW_FOLLOWER_ASSERT_SVH

// antecedent in one cycle implies consequent in the next, outside reset
`define ADSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("adsf check failed");

// same form, also active while reset is held
`define ADSF_ASSERT_NEXT_NR(label, ante, cons) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error("adsf check failed");

`endif

// ===== rtl/adsf_pkg.sv =====
// ----------------------------------------------------------------------------
// adsf_pkg
// types and constants shared by the slew follower modules
// ----------------------------------------------------------------------------
package adsf_pkg;

    localparam int ADSF_DECAY_STEPS = 10;

    localparam int VAL_W      = 32;
    localparam int STEP_W     = 31;
    localparam int FRAC_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W = 128;
    localparam int DVD_W      = 49;
    localparam int DVS_W      = 31;

    localparam logic [FRAC_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [32:0]       GAP_LIMIT = 33'd655;

    // x / 10 as (x * RECIP10) >> RECIP10_SH, exact for 17 bit x
    localparam logic [19:0] RECIP10    = 20'hCCCCD;
    localparam int          RECIP10_SH = 23;
    localparam int          DEC_STEP_MAX = 6554;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SPEED,
        CFG_MAX_SPEED,
        CFG_ACCEL_FRACTION,
        CFG_DECEL_FRACTION
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC_INIT,
        ST_DEC_MUL,
        ST_DEC_CMP,
        ST_DEC_DIV,
        ST_DEC_ACC,
        ST_UP_GAP,
        ST_UP_S1,
        ST_UP_S1C,
        ST_UP_DK,
        ST_UP_A1,
        ST_UP_A2,
        ST_UP_CMUL,
        ST_UP_CCMP,
        ST_UP_DIV,
        ST_UP_NV,
        ST_UP_NV2,
        ST_UP_OUT
    } t_state;

endpackage

// ===== rtl/adsf_div.sv =====
// ----------------------------------------------------------------------------
// adsf_div
// restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module adsf_div
    import adsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/accel_decay_slew_follower.sv =====
// ----------------------------------------------------------------------------
// accel_decay_slew_follower
// moves a value toward a target with a kept velocity, signed Q16.16
//
// channel   direction  tdata fields (low bit up)                       tuser
// s_axis    in         current_value, target_value, time_step,         operation
//                      load_velocity, one pad bit
// m_axis    out        next_value                                      -
// cfg       in         index selects register, data holds its value    -
//
// an update takes the decay path or the accel path, or for a small gap gives the target;
// a clamp division runs a 49-step serial divider, all products share one multiplier
// a velocity load gives no transaction on m_axis
// after reset and after each config write the decay time is rebuilt
// over at most DECAY_STEPS steps, inputs not ready meanwhile
// reset is synchronous, active low; a stalled result is held in the output register
// ----------------------------------------------------------------------------
module accel_decay_slew_follower
    import adsf_pkg::*;
#(
    parameter int DECAY_STEPS = ADSF_DECAY_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // current_value[31:0], target_value[63:32], time_step[94:64],
    // load_velocity[126:95], zero[127]
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    // operation[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // next_value[31:0]
    output logic [VAL_W-1:0]      o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [STEP_W-1:0]     i_cfg_data
);

    localparam int DT_W = $clog2(DECAY_STEPS * DEC_STEP_MAX + 1);
    localparam int I_W  = $clog2(DECAY_STEPS + 1);
    localparam logic [I_W-1:0] STEPS_C = I_W'(DECAY_STEPS);

    function automatic logic [VAL_W-1:0] sat32(input logic [63:0] x);
        logic [VAL_W-1:0] res;
        if (!x[63] && (x[62:31] != '0)) begin
            res = 32'h7FFF_FFFF;
        end else if (x[63] && (x[62:31] != '1)) begin
            res = 32'h8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    t_state r_state;
    t_state n_state;

    // configuration
    logic [STEP_W-1:0] r_min;
    logic [STEP_W-1:0] r_max;
    logic [FRAC_W-1:0] r_accel;
    logic [FRAC_W-1:0] r_decel;

    // kept state
    logic [VAL_W-1:0]  r_vel;
    logic [DT_W-1:0]   r_dt;

    // decay time sequencer
    logic [FRAC_W-1:0] r_d;
    logic [DT_W-1:0]   r_sum;
    logic [I_W-1:0]    r_i;

    // update working registers
    logic [VAL_W-1:0]  r_cur;
    logic [VAL_W-1:0]  r_tgt;
    logic [STEP_W-1:0] r_step;
    logic [VAL_W-1:0]  r_v;
    logic              r_neg;
    logic [32:0]       r_adelta;
    logic [49:0]       r_acc;
    logic              r_branch;
    logic              r_sneg;
    logic [VAL_W-1:0]  r_res;
    logic [63:0]       r_prod;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_data;

    logic              in_acc;
    logic              cfg_acc;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;

    logic [FRAC_W-1:0] acc_f;
    logic [FRAC_W-1:0] dec_f;
    logic [FRAC_W-1:0] keep_dec;
    logic [FRAC_W-1:0] keep_acc;
    logic [32:0]       delta;
    logic [32:0]       adelta;
    logic [32:0]       vel33;
    logic [32:0]       v33;
    logic [32:0]       s33;
    logic [31:0]       vel_abs;
    logic [31:0]       v_abs;
    logic              s_pos;
    logic [63:0]       gap64;
    logic [DVS_W-1:0]  dvs;
    logic              dec_go;
    logic              fast_hit;
    logic              clamp;
    logic [VAL_W-1:0]  v_start;
    logic [63:0]       dk64;
    logic [49:0]       p2;
    logic [49:0]       num;
    logic [49:0]       num_mag;
    logic [63:0]       a64;
    logic [63:0]       q64;
    logic [32:0]       sum33;
    logic [32:0]       sum_mag;
    logic [63:0]       tv64;
    logic [63:0]       nv64;
    logic [32:0]       mul_a;
    logic [30:0]       mul_b;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;

    // datapath helpers
    always_comb begin
        acc_f    = (r_accel > ONE_Q16) ? ONE_Q16 : r_accel;
        dec_f    = (r_decel > ONE_Q16) ? ONE_Q16 : r_decel;
        keep_dec = ONE_Q16 - dec_f;
        keep_acc = ONE_Q16 - acc_f;

        delta  = {r_tgt[31], r_tgt} - {r_cur[31], r_cur};
        adelta = delta[32] ? (33'd0 - delta) : delta;

        vel33   = {r_vel[31], r_vel};
        v33     = {r_v[31], r_v};
        vel_abs = r_vel[31] ? 32'(33'd0 - vel33) : r_vel;
        v_abs   = r_v[31] ? 32'(33'd0 - v33) : r_v;
        s33     = r_neg ? (33'd0 - v33) : v33;
        s_pos   = !s33[32] && (s33 != '0);

        v_start = r_vel;
        if (vel_abs < {1'b0, r_min}) begin
            v_start = delta[32] ? 32'(33'd0 - {2'b0, r_min}) : {1'b0, r_min};
        end

        gap64    = {15'd0, r_adelta, 16'd0};
        fast_hit = s_pos && (gap64 < r_prod);
        dvs      = r_branch ? r_step : DVS_W'(r_dt);
        clamp    = fast_hit && (dvs != '0);
        dec_go   = (r_prod[47:0] > {1'b0, r_min, 16'd0}) && (r_i < STEPS_C);

        dk64 = r_v[31] ? (64'd0 - {32'd0, r_prod[47:16]}) : {32'd0, r_prod[47:16]};

        p2      = {2'b0, r_prod[47:0]};
        num     = r_acc + (r_neg ? (50'd0 - p2) : p2);
        num_mag = num[49] ? (50'd0 - num) : num;
        a64     = num[49] ? (64'd0 - {31'd0, num_mag[48:16]}) : {31'd0, num_mag[48:16]};

        q64 = r_neg ? (64'd0 - {15'd0, div_quo}) : {15'd0, div_quo};

        sum33   = vel33 + v33;
        sum_mag = sum33[32] ? (33'd0 - sum33) : sum33;
        tv64    = r_sneg ? (64'd0 - {17'd0, r_prod[63:17]}) : {17'd0, r_prod[63:17]};
        nv64    = {{32{r_cur[31]}}, r_cur} + tv64;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cfg_acc) begin
                    n_state = ST_DEC_INIT;
                end else if (in_acc && (i_s_axis_tuser == OP_UPDATE)) begin
                    n_state = ST_UP_GAP;
                end
            end
            ST_DEC_INIT: n_state = ST_DEC_MUL;
            ST_DEC_MUL:  n_state = ST_DEC_CMP;
            ST_DEC_CMP:  n_state = dec_go ? ST_DEC_DIV : ST_IDLE;
            ST_DEC_DIV:  n_state = ST_DEC_ACC;
            ST_DEC_ACC:  n_state = ST_DEC_MUL;
            ST_UP_GAP:   n_state = (adelta <= GAP_LIMIT) ? ST_UP_OUT : ST_UP_S1;
            ST_UP_S1:    n_state = ST_UP_S1C;
            ST_UP_S1C:   n_state = fast_hit ? ST_UP_DK : ST_UP_A1;
            ST_UP_DK:    n_state = ST_UP_CMUL;
            ST_UP_A1:    n_state = ST_UP_A2;
            ST_UP_A2:    n_state = ST_UP_CMUL;
            ST_UP_CMUL:  n_state = ST_UP_CCMP;
            ST_UP_CCMP:  n_state = clamp ? ST_UP_DIV : ST_UP_NV;
            ST_UP_DIV:   n_state = div_done ? ST_UP_NV : ST_UP_DIV;
            ST_UP_NV:    n_state = ST_UP_NV2;
            ST_UP_NV2:   n_state = ST_UP_OUT;
            ST_UP_OUT:   n_state = out_free ? ST_IDLE : ST_UP_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_cfg_ready     = 1'b0;
        div_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cfg_ready     = 1'b1;
                o_s_axis_tready = !i_cfg_valid;
            end
            ST_DEC_MUL: begin
                mul_a = 33'(r_d);
                mul_b = r_max;
            end
            ST_DEC_CMP: begin
                mul_a = 33'(r_d);
                mul_b = 31'(keep_dec);
            end
            ST_DEC_DIV: begin
                mul_a = 33'({1'b0, r_prod[32:16]} + 18'd5);
                mul_b = 31'(RECIP10);
            end
            ST_UP_S1: begin
                mul_a = 33'(s33[31:0]);
                mul_b = 31'(r_dt);
            end
            ST_UP_S1C: begin
                mul_a = 33'(v_abs);
                mul_b = fast_hit ? 31'(keep_dec) : 31'(keep_acc);
            end
            ST_UP_A1: begin
                mul_a = 33'(r_max);
                mul_b = 31'(acc_f);
            end
            ST_UP_CMUL: begin
                mul_a = 33'(s33[31:0]);
                mul_b = r_branch ? r_step : 31'(r_dt);
            end
            ST_UP_CCMP: begin
                div_start = clamp;
            end
            ST_UP_NV: begin
                mul_a = sum_mag;
                mul_b = r_step;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DEC_INIT;
            r_min       <= '0;
            r_max       <= '0;
            r_accel     <= '0;
            r_decel     <= '0;
            r_vel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_SPEED:      r_min   <= i_cfg_data;
                    CFG_MAX_SPEED:      r_max   <= i_cfg_data;
                    CFG_ACCEL_FRACTION: r_accel <= i_cfg_data[FRAC_W-1:0];
                    CFG_DECEL_FRACTION: r_decel <= i_cfg_data[FRAC_W-1:0];
                endcase
            end
            if (in_acc && (i_s_axis_tuser == OP_LOAD)) begin
                r_vel <= i_s_axis_tdata[126:95];
            end
            if (r_state == ST_UP_NV) begin
                r_vel <= r_v;
            end
            if ((r_state == ST_UP_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {31'd0, mul_a} * {33'd0, mul_b};
        if ((r_state == ST_UP_OUT) && out_free) begin
            r_out_data <= r_res;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_cur  <= i_s_axis_tdata[31:0];
                r_tgt  <= i_s_axis_tdata[63:32];
                r_step <= i_s_axis_tdata[94:64];
            end
            ST_DEC_INIT: begin
                r_d   <= ONE_Q16;
                r_sum <= '0;
                r_i   <= '0;
            end
            ST_DEC_CMP: begin
                if (!dec_go) begin
                    r_dt <= r_sum;
                end
            end
            ST_DEC_DIV: begin
                r_d <= r_prod[32:16];
            end
            ST_DEC_ACC: begin
                r_sum <= r_sum + DT_W'(r_prod[RECIP10_SH+12:RECIP10_SH]);
                r_i   <= r_i + 1'b1;
            end
            ST_UP_GAP: begin
                r_res    <= r_tgt;
                r_neg    <= delta[32];
                r_adelta <= adelta;
                r_v      <= v_start;
            end
            ST_UP_S1C: begin
                r_branch <= fast_hit;
            end
            ST_UP_DK: begin
                r_v <= sat32(dk64);
            end
            ST_UP_A1: begin
                r_acc <= r_v[31] ? (50'd0 - {2'b0, r_prod[47:0]}) : {2'b0, r_prod[47:0]};
            end
            ST_UP_A2: begin
                r_v <= sat32(a64);
            end
            ST_UP_DIV: begin
                if (div_done) begin
                    r_v <= sat32(q64);
                end
            end
            ST_UP_NV: begin
                r_sneg <= sum33[32];
            end
            ST_UP_NV2: begin
                r_res <= sat32(nv64);
            end
            default: begin
            end
        endcase
    end

    adsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_adelta, 16'd0}),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/adsf_chk.sv =====
// ----------------------------------------------------------------------------
// adsf_chk
// port level checks for the slew follower, bound to the top level
// ----------------------------------------------------------------------------
`include "accel_decay_slew_follower_assert.svh"

module adsf_chk
    import adsf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_user,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VAL_W-1:0] i_out_data,
    input logic             i_cfg_valid,
    input logic             i_cfg_ready
);

    // a stalled result stays put
    `ADSF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // an update transaction keeps the block busy in the cycle after it
    `ADSF_ASSERT_NEXT(a_update_busy, i_in_valid && i_in_ready && (i_in_user == OP_UPDATE), !i_in_ready)

    // a config write starts the decay rebuild
    `ADSF_ASSERT_NEXT(a_cfg_rebuild, i_cfg_valid && i_cfg_ready, !i_in_ready && !i_cfg_ready)

    // reset leaves no result and rebuilds decay first
    `ADSF_ASSERT_NEXT_NR(a_reset_quiet, !i_rst_n, !i_in_ready && !i_out_valid)

endmodule

bind accel_decay_slew_follower adsf_chk u_adsf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_s_axis_tvalid),
    .i_in_ready  (o_s_axis_tready),
    .i_in_user   (i_s_axis_tuser),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata),
    .i_cfg_valid (i_cfg_valid),
    .i_cfg_ready (o_cfg_ready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for accel_decay_slew_follower
// drives update and velocity load transactions with random stalls on both
// stream sides, predicts every next_value from a local copy of the velocity,
// decay time and registers, and compares each output transaction in order
// ----------------------------------------------------------------------------
module testbench;
    import adsf_pkg::*;

    localparam longint UNIT        = 64'sd65536;
    localparam longint GAP_RAW     = 64'sd655;
    localparam int     STALL_LIMIT = 4000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     TAIL_CYCLES = 100;
    localparam int     NUM_PHASES  = 8;
    localparam int     PHASE_ITEMS = 215;

    typedef struct {
        logic                    op;
        logic signed [VAL_W-1:0] cur;
        logic signed [VAL_W-1:0] tgt;
        logic [STEP_W-1:0]       step;
        logic signed [VAL_W-1:0] lvel;
        bit                      trail;
    } t_slew_item;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [VAL_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = CFG_MIN_SPEED;
    logic [STEP_W-1:0]     cfg_data = '0;

    t_slew_item            update_q[$];
    logic [VAL_W-1:0]      next_value_q[$];
    t_slew_item            s_item;
    logic                  s_taken = 1'b0;
    int                    s_gap = 0;
    int                    r_gap = 0;
    int                    hold_cnt = 0;
    bit                    hold_flip = 1'b0;
    bit                    hold_seen = 1'b0;
    bit                    calm = 1'b0;
    int                    errors = 0;
    int                    quiet_cycles = 0;
    logic [VAL_W-1:0]      want;
    logic signed [VAL_W-1:0] trail_pos = '0;

    // local copy of block state and registers
    longint                min_spd = 0;
    longint                max_spd = 0;
    longint                accel_fr = 0;
    longint                decel_fr = 0;
    longint                vel = 0;
    longint                decay_q = 0;

    accel_decay_slew_follower DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint frac_clip(longint f);
        return (f > UNIT) ? UNIT : f;
    endfunction

    function automatic void rebuild_decay();
        longint keep;
        longint d;
        longint sum;
        int     n;
        keep = UNIT - frac_clip(decel_fr);
        d = UNIT;
        sum = 0;
        n = 0;
        while (d * max_spd > (min_spd <<< 16) && n < ADSF_DECAY_STEPS) begin
            d = (d * keep) >>> 16;
            sum += (d + 5) / 10;
            n++;
        end
        decay_q = sum;
    endfunction

    function automatic void take_cfg(t_cfg_idx idx, logic [STEP_W-1:0] data);
        case (idx)
            CFG_MIN_SPEED:      min_spd = data;
            CFG_MAX_SPEED:      max_spd = data;
            CFG_ACCEL_FRACTION: accel_fr = data[FRAC_W-1:0];
            CFG_DECEL_FRACTION: decel_fr = data[FRAC_W-1:0];
            default: ;
        endcase
        rebuild_decay();
    endfunction

    function automatic void predict_follow(t_slew_item it);
        longint cur, tgt, stp, delta, sgn, adelta, gap16, v, oldv, a, kp, num, nv;
        if (it.op == OP_LOAD) begin
            vel = it.lvel;
            return;
        end
        cur = it.cur;
        tgt = it.tgt;
        stp = it.step;
        delta = tgt - cur;
        sgn = (delta < 0) ? -64'sd1 : 64'sd1;
        adelta = (delta < 0) ? -delta : delta;
        if (adelta <= GAP_RAW) begin
            next_value_q.push_back(it.tgt);
            trail_pos = it.tgt;
            return;
        end
        oldv = vel;
        v = vel;
        if (((v < 0) ? -v : v) < min_spd)
            v = min_spd * sgn;
        gap16 = adelta * UNIT;
        if (gap16 < v * sgn * decay_q) begin
            kp = UNIT - frac_clip(decel_fr);
            v = clip32((v * kp) / UNIT);
            if (gap16 < v * sgn * stp && stp != 0)
                v = clip32((gap16 * sgn) / stp);
        end else begin
            a = frac_clip(accel_fr);
            num = v * (UNIT - a) + max_spd * a * sgn;
            v = clip32(num / UNIT);
            if (gap16 < v * sgn * decay_q && decay_q != 0)
                v = clip32((gap16 * sgn) / decay_q);
        end
        vel = v;
        nv = clip32(cur + ((oldv + v) * stp) / (2 * UNIT));
        next_value_q.push_back(nv[VAL_W-1:0]);
        trail_pos = nv[VAL_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] exp);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, exp);
        errors++;
    endtask

    // output check and prediction share one block so their order is fixed
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (next_value_q.size() == 0) begin
                report_mismatch("unexpected next_value", m_tdata, 'x);
            end else begin
                want = next_value_q.pop_front();
                if (m_tdata !== want)
                    report_mismatch("next_value", m_tdata, want);
            end
        end
        if (rst_n && s_tvalid && s_tready)
            predict_follow(s_item);
        s_taken <= rst_n && s_tvalid && s_tready;
    end

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 8) begin
                s_gap = $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end else if (update_q.size() != 0) begin
                s_item = update_q.pop_front();
                if (s_item.trail)
                    s_item.cur = trail_pos;
                s_tdata  <= {1'b0, s_item.lvel, s_item.step, s_item.tgt, s_item.cur};
                s_tuser  <= s_item.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output receiver
    always @(negedge clk) begin
        if (hold_flip != hold_seen) begin
            hold_seen = hold_flip;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (r_gap > 0) begin
            r_gap--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 8) begin
            r_gap = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_update(logic signed [VAL_W-1:0] cur, logic signed [VAL_W-1:0] tgt,
                               logic [STEP_W-1:0] step, bit trail);
        t_slew_item it;
        it.op = OP_UPDATE;
        it.cur = cur;
        it.tgt = tgt;
        it.step = step;
        it.lvel = $urandom;
        it.trail = trail;
        update_q.push_back(it);
    endtask

    task automatic push_load(logic signed [VAL_W-1:0] v);
        t_slew_item it;
        it.op = OP_LOAD;
        it.cur = $urandom;
        it.tgt = $urandom;
        it.step = STEP_W'($urandom);
        it.lvel = v;
        it.trail = 1'b0;
        update_q.push_back(it);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [STEP_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        take_cfg(idx, data);
    endtask

    task automatic set_config(logic [STEP_W-1:0] mn, logic [STEP_W-1:0] mx,
                              logic [STEP_W-1:0] ac, logic [STEP_W-1:0] dc);
        cfg_write(CFG_MIN_SPEED, mn);
        cfg_write(CFG_MAX_SPEED, mx);
        cfg_write(CFG_ACCEL_FRACTION, ac);
        cfg_write(CFG_DECEL_FRACTION, dc);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all items taken, all results seen, then let a trailing load finish
    task automatic settle();
        while (update_q.size() != 0 || s_tvalid || next_value_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 75) return STEP_W'($urandom_range(1, 32'h8000));
        if (roll < 92) return STEP_W'($urandom_range(0, 32'h40000));
        return STEP_W'($urandom);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_pos();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 32'h8000000) - 32'h4000000;
        return $urandom;
    endfunction

    function automatic logic [STEP_W-1:0] pick_frac();
        if ($urandom_range(0, 99) < 20) return STEP_W'($urandom);
        return STEP_W'($urandom_range(0, 65536));
    endfunction

    task automatic queue_random(int count);
        int n;
        int len;
        int roll;
        logic signed [VAL_W-1:0] goal;
        n = 0;
        while (n < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                if ($urandom_range(0, 1))
                    push_load($urandom);
                else
                    push_load($urandom_range(0, 32'h2000000) - 32'h1000000);
                n++;
            end else if (roll < 20) begin
                push_update($urandom, $urandom, pick_step(), 1'b0);
                n++;
            end else begin
                goal = pick_pos();
                len = $urandom_range(4, 24);
                push_update(pick_pos(), goal, pick_step(), $urandom_range(0, 1));
                for (int k = 1; k < len; k++)
                    push_update('0, goal, pick_step(), 1'b1);
                n += len;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: decay time zero, velocity kept by the blend
        push_load(32'sh7FFFFFFF);
        push_update(32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, 1'b0);
        push_load(32'sh80000000);
        push_update(32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 1'b0);
        push_update(32'sh00000000, 32'sh0000028F, 31'h00010000, 1'b0);
        push_update(32'sh000003E8, 32'sh00000159, 31'h00010000, 1'b0);
        push_update(32'sh00000000, 32'sh00000290, 31'h00010000, 1'b0);
        push_update(32'sh00100000, 32'shFFF00000, 31'h00000000, 1'b0);
        settle();

        set_config(31'h8000, 31'hA0000, 31'h4000, 31'h199A);
        push_load(32'sh00000000);
        push_update(32'sh00000000, 32'sh00640000, 31'd6554, 1'b0);
        repeat (4) push_update('0, 32'sh00640000, 31'd6554, 1'b1);
        push_load(32'sh00320000);
        push_update(32'sh00000000, 32'sh00010000, 31'h4000, 1'b0);
        push_load(32'sh00320000);
        push_update(32'sh00000000, 32'sh00010000, 31'h0000, 1'b0);
        push_load(32'shFFCE0000);
        push_update(32'sh00000000, 32'shFFFF0000, 31'h4000, 1'b0);
        settle();

        // fractions above one
        set_config(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1FFFF, 31'h1FFFF);
        push_update(32'sh00000000, 32'sh7FFFFFFF, 31'h00010000, 1'b0);
        push_update(32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 1'b0);
        push_load(32'sh80000000);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_config(31'h0, 31'h7FFFFFFF, 31'd65536, 31'h0);
                1: set_config(31'h7FFFFFFF, 31'h0, 31'h0, 31'd65536);
                default: begin
                    if ($urandom_range(0, 99) < 75)
                        set_config(STEP_W'($urandom_range(0, 32'h80000)),
                                   STEP_W'($urandom_range(0, 32'h1000000)),
                                   pick_frac(), pick_frac());
                    else
                        set_config(STEP_W'($urandom), STEP_W'($urandom),
                                   pick_frac(), pick_frac());
                end
            endcase
            if (p == 3)
                hold_flip = ~hold_flip;
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            queue_random(PHASE_ITEMS);
            settle();
        end

        if (errors == 0 && next_value_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
